### hw/rtl/usm_pkg.sv
package usm_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_SHARPEN_GAIN = 2'd2;

    // Reset values of the configuration registers
    localparam logic [10:0] WIDTH_RESET  = 11'd512;
    localparam logic [15:0] HEIGHT_RESET = 16'd512;
    localparam logic [9:0]  GAIN_RESET   = 10'd77;

    // Smallest legal image side and number of row slots in the line store
    localparam int MIN_SIDE   = 5;
    localparam int STORE_ROWS = 5;

    // floor(x / 50) for x below 2^14 as (x * BLUR_RECIP) >> BLUR_SHIFT
    localparam logic [12:0] BLUR_RECIP = 13'd5243;
    localparam int          BLUR_SHIFT = 18;

    // One byte for each row slot of a column
    typedef logic [STORE_ROWS-1:0][7:0] usm_lanes_t;

    // Per-pixel control that travels down the pipeline
    typedef struct packed {
        logic       border;
        logic       last;
        logic       top_mirror;
        logic       bot_mirror;
        logic       left_mirror;
        logic       right_mirror;
        logic [2:0] slot;
    } usm_meta_t;

    // Row slot s advanced by k rows, modulo the slot count
    function automatic logic [2:0] slot_add(logic [2:0] s, logic [2:0] k);
        logic [3:0] t;
        begin
            t = {1'b0, s} + {1'b0, k};
            if (t >= 4'(STORE_ROWS))
            begin
                t = t - 4'(STORE_ROWS);
            end
            return t[2:0];
        end
    endfunction

    // Vertical five-tap sum of one column, with rows mirrored at the edges
    function automatic logic [10:0] col_sum(usm_lanes_t l, logic [2:0] s,
                                            logic tm, logic bm);
        logic [2:0] sm2;
        logic [2:0] sm1;
        logic [2:0] sp1;
        logic [2:0] sp2;
        logic [2:0] t;
        logic [2:0] b;
        begin
            sm2 = slot_add(s, 3'd3);
            sm1 = slot_add(s, 3'd4);
            sp1 = slot_add(s, 3'd1);
            sp2 = slot_add(s, 3'd2);
            t   = tm ? sp2 : sm2;
            b   = bm ? sm2 : sp2;
            return 11'(l[t]) + 11'(l[sm1]) + 11'(l[s]) + 11'(l[sp1]) + 11'(l[b]);
        end
    endfunction

endpackage

### hw/rtl/usm_in_if.sv
interface usm_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] pixel_in;

    modport source (output valid, output action, output pixel_in, input ready);
    modport sink (input valid, input action, input pixel_in, output ready);
endinterface

### hw/rtl/usm_out_if.sv
interface usm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_out;
    logic       frame_end;

    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

### hw/rtl/usm_store.sv
module usm_store
    import usm_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int AW        = 10
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_col,
    input  logic [2:0]    wr_slot,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_col_a,
    input  logic [AW-1:0] rd_col_b,
    output usm_lanes_t    lanes_a,
    output usm_lanes_t    lanes_b
);

    // Line store: one word per column, one byte lane per row slot
    usm_lanes_t mem [MAX_WIDTH];

    usm_lanes_t rd_a_reg;
    usm_lanes_t rd_b_reg;
    logic       fwd_a_reg;
    logic       fwd_b_reg;
    logic [2:0] fwd_slot_reg;
    logic [7:0] fwd_data_reg;

    // Byte-lane write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_col][wr_slot] <= wr_data;
        end
    end

    // Two registered reads; a write to the same column in the same cycle is
    // remembered so that the new byte replaces the stale lane.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg     <= mem[rd_col_a];
            rd_b_reg     <= mem[rd_col_b];
            fwd_a_reg    <= wr_en && (wr_col == rd_col_a);
            fwd_b_reg    <= wr_en && (wr_col == rd_col_b);
            fwd_slot_reg <= wr_slot;
            fwd_data_reg <= wr_data;
        end
    end

    always_comb
    begin
        lanes_a = rd_a_reg;
        lanes_b = rd_b_reg;
        if (fwd_a_reg)
        begin
            lanes_a[fwd_slot_reg] = fwd_data_reg;
        end
        if (fwd_b_reg)
        begin
            lanes_b[fwd_slot_reg] = fwd_data_reg;
        end
    end

endmodule

### hw/rtl/unsharp_mask_box5_filter_unit.sv
// Channel   Dir  Payload                 Handshake
// pix_in    in   action, pixel_in        valid/ready
// pix_out   out  pixel_out, frame_end    valid/ready
// cfg       in   cfg_index, cfg_data     cfg_we, no wait
//
// One input word per clock while pix_in.ready is high. A result passes stages
// 1 to 4 and the output register after the word that completes its 5x5 window;
// the first 2*W+2 pixels of a frame give no result, and flush words drain the
// last 2*W+2 results. The rate is set by the line store: one write and two
// column reads a cycle. Reset clears the counters and pipeline valids; the line
// store is not cleared. When the output register is full and not taken, the
// stages behind it close their bubbles first, then input ready drops.
module unsharp_mask_box5_filter_unit
    import usm_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic          clk,
    input  logic          rst_n,
    usm_in_if.sink        pix_in,
    usm_out_if.source     pix_out,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PW = CW + 2;

    // Configuration registers
    logic [10:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic [9:0]  sharpen_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            sharpen_gain_reg <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[10:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                CFG_SHARPEN_GAIN: sharpen_gain_reg <= cfg_data[9:0];
                default:          ;
            endcase
        end
    end

    // Effective image size
    logic [CW-1:0] w_eff;
    logic [15:0]   h_eff;

    always_comb
    begin
        if (image_width_reg < 11'(MIN_SIDE))
        begin
            w_eff = CW'(MIN_SIDE);
        end
        else if (int'(image_width_reg) > MAX_WIDTH)
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CW'(image_width_reg);
        end
        h_eff = (image_height_reg < 16'(MIN_SIDE)) ? 16'(MIN_SIDE) : image_height_reg;
    end

    // Pipeline handshake: each stage loads when empty or when it moves on
    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic ld1, ld2, ld3, ld4, ldo;
    logic accept;

    assign ldo = !vo_reg || pix_out.ready;
    assign ld4 = !v4_reg || ldo;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;
    assign pix_in.ready = ld1;
    assign accept = pix_in.valid && ld1;

    // Frame counters
    logic [15:0]   in_row_reg, in_row_next;
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [2:0]    in_slot_reg, in_slot_next;
    logic [15:0]   out_row_reg, out_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [2:0]    out_slot_reg, out_slot_next;
    logic [PW-1:0] pend_reg, pend_next;

    logic          done_now;
    logic          done_after;
    logic          wr_en;
    logic          emit;
    logic          last_px;
    logic [PW-1:0] pend_inc;
    logic [PW-1:0] owed_gap;
    usm_meta_t     meta0;

    always_comb
    begin
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_slot_next  = in_slot_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_slot_next = out_slot_reg;
        pend_next     = pend_reg;

        done_now = in_row_reg >= h_eff;
        wr_en    = accept && !pix_in.action && !done_now;
        owed_gap = PW'({w_eff, 1'b0}) + PW'(2);
        pend_inc = pend_reg + PW'(1);

        // Store the pixel and step the input position
        done_after = done_now;
        if (wr_en)
        begin
            in_col_next = in_col_reg + CW'(1);
            pend_next   = pend_inc;
            if (in_col_next >= w_eff)
            begin
                in_col_next  = '0;
                in_row_next  = in_row_reg + 16'd1;
                in_slot_next = slot_add(in_slot_reg, 3'd1);
            end
            done_after = in_row_next >= h_eff;
            emit = done_after || (pend_inc > owed_gap);
        end
        else
        begin
            emit = accept && done_now;
        end

        last_px = (out_row_reg > h_eff - 16'd1)
               || ((out_row_reg == h_eff - 16'd1) && (out_col_reg >= w_eff - CW'(1)));

        // Describe the pixel that leaves and step the output position
        meta0.border = (out_row_reg == 16'd0) || (out_col_reg == '0)
                    || ({1'b0, out_row_reg} + 17'd1 >= {1'b0, h_eff})
                    || ({1'b0, out_col_reg} + (CW+1)'(1) >= {1'b0, w_eff});
        meta0.last         = last_px;
        meta0.top_mirror   = out_row_reg < 16'd2;
        meta0.bot_mirror   = {1'b0, out_row_reg} + 17'd2 >= {1'b0, h_eff};
        meta0.left_mirror  = out_col_reg < CW'(2);
        meta0.right_mirror = {1'b0, out_col_reg} + (CW+1)'(2) >= {1'b0, w_eff};
        meta0.slot         = out_slot_reg;

        if (emit)
        begin
            pend_next = pend_next - PW'(1);
            if (last_px)
            begin
                in_row_next   = '0;
                in_col_next   = '0;
                in_slot_next  = '0;
                out_row_next  = '0;
                out_col_next  = '0;
                out_slot_next = '0;
                pend_next     = '0;
            end
            else
            begin
                out_col_next = out_col_reg + CW'(1);
                if (out_col_next >= w_eff)
                begin
                    out_col_next  = '0;
                    out_row_next  = out_row_reg + 16'd1;
                    out_slot_next = slot_add(out_slot_reg, 3'd1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            pend_reg     <= '0;
        end
        else if (accept)
        begin
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_slot_reg  <= in_slot_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_slot_reg <= out_slot_next;
            pend_reg     <= pend_next;
        end
    end

    // Line store: column c for the centre, column c+2 for the new column sum
    usm_lanes_t lanes_a;
    usm_lanes_t lanes_b;

    usm_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_col   (in_col_reg[AW-1:0]),
        .wr_slot  (in_slot_reg),
        .wr_data  (pix_in.pixel_in),
        .rd_en    (ld1),
        .rd_col_a (out_col_reg[AW-1:0] + AW'(2)),
        .rd_col_b (out_col_reg[AW-1:0]),
        .lanes_a  (lanes_a),
        .lanes_b  (lanes_b)
    );

    // Valid bits of the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= accept && emit;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
            if (ld4)
            begin
                v4_reg <= v3_reg;
            end
            if (ldo)
            begin
                vo_reg <= v4_reg;
            end
        end
    end

    // Stage 1: read data arrives; form the two column sums and the centre
    usm_meta_t   m1_reg;
    logic [10:0] cs_a1;
    logic [10:0] cs_b1;

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            m1_reg <= meta0;
        end
    end

    assign cs_a1 = col_sum(lanes_a, m1_reg.slot, m1_reg.top_mirror, m1_reg.bot_mirror);
    assign cs_b1 = col_sum(lanes_b, m1_reg.slot, m1_reg.top_mirror, m1_reg.bot_mirror);

    // Stage 2: column sums; the window adds two older centre-column sums and
    // one older right-column sum, mirrored at the left and right edges.
    usm_meta_t   m2_reg;
    logic [10:0] cs_a2_reg;
    logic [10:0] cs_b2_reg;
    logic [7:0]  cen2_reg;
    logic [10:0] hist_b1_reg;
    logic [10:0] hist_b2_reg;
    logic [10:0] hist_a1_reg;
    logic [10:0] left2;
    logic [10:0] right2;
    logic [12:0] win_sum;

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            m2_reg    <= m1_reg;
            cs_a2_reg <= cs_a1;
            cs_b2_reg <= cs_b1;
            cen2_reg  <= lanes_b[m1_reg.slot];
        end
        if (ld3 && v2_reg)
        begin
            hist_b2_reg <= hist_b1_reg;
            hist_b1_reg <= cs_b2_reg;
            hist_a1_reg <= cs_a2_reg;
        end
    end

    assign left2   = m2_reg.left_mirror ? cs_a2_reg : hist_b2_reg;
    assign right2  = m2_reg.right_mirror ? hist_b2_reg : cs_a2_reg;
    assign win_sum = 13'(left2) + 13'(hist_b1_reg) + 13'(cs_b2_reg)
                   + 13'(hist_a1_reg) + 13'(right2);

    // Stage 3: rounded blur by reciprocal multiplication
    logic        border3_reg;
    logic        last3_reg;
    logic [7:0]  cen3_reg;
    logic [12:0] sum3_reg;
    logic [13:0] blur_num;
    logic [26:0] blur_prod;

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            border3_reg <= m2_reg.border;
            last3_reg   <= m2_reg.last;
            cen3_reg    <= cen2_reg;
            sum3_reg    <= win_sum;
        end
    end

    assign blur_num  = {sum3_reg, 1'b0} + 14'd25;
    assign blur_prod = 27'(blur_num) * 27'(BLUR_RECIP);

    // Stage 4: weighted detail, rounding and clamping
    logic              border4_reg;
    logic              last4_reg;
    logic [7:0]        cen4_reg;
    logic [7:0]        blur4_reg;
    logic signed [8:0]  detail;
    logic signed [19:0] gain_prod;
    logic signed [20:0] sharp_acc;
    logic [7:0]         sharp_px;

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            border4_reg <= border3_reg;
            last4_reg   <= last3_reg;
            cen4_reg    <= cen3_reg;
            blur4_reg   <= blur_prod[BLUR_SHIFT+7:BLUR_SHIFT];
        end
    end

    always_comb
    begin
        detail    = $signed({1'b0, cen4_reg}) - $signed({1'b0, blur4_reg});
        gain_prod = $signed({1'b0, sharpen_gain_reg}) * 20'(detail);
        sharp_acc = $signed({5'b0, cen4_reg, 8'b0}) + 21'(gain_prod) + 21'sd128;
        if (border4_reg)
        begin
            sharp_px = cen4_reg;
        end
        else if (sharp_acc < 21'sd0)
        begin
            sharp_px = 8'd0;
        end
        else if (sharp_acc[20:8] > 13'd255)
        begin
            sharp_px = 8'd255;
        end
        else
        begin
            sharp_px = sharp_acc[15:8];
        end
    end

    // Output register
    logic [7:0] pix_o_reg;
    logic       last_o_reg;

    always_ff @(posedge clk)
    begin
        if (ldo)
        begin
            pix_o_reg  <= sharp_px;
            last_o_reg <= last4_reg;
        end
    end

    assign pix_out.valid     = vo_reg;
    assign pix_out.pixel_out = pix_o_reg;
    assign pix_out.frame_end = last_o_reg;

`ifndef SYNTHESIS
    // A word that owes a result starts down the pipeline.
    a_emit_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit) |=> v1_reg)
        else $error("emitting word did not enter the pipeline");

    // A word that owes no result leaves a bubble.
    a_quiet_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !emit) |=> !v1_reg)
        else $error("result created for a word that owes none");

    // The last pixel of a frame returns every counter to the start.
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit && last_px) |=>
            (in_row_reg == 16'd0 && in_col_reg == '0 && out_row_reg == 16'd0
             && out_col_reg == '0 && pend_reg == '0))
        else $error("counters not cleared after frame end");
`endif

endmodule

### test/testbench.sv
module testbench
    import usm_pkg::*;
();

    localparam int MAX_W = 1024;
    localparam int RUN_LIMIT = 3000000;
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] pixel;
    } word_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_end;
    } sharp_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    usm_in_if  pix_in ();
    usm_out_if pix_out ();

    unsharp_mask_box5_filter_unit #(.MAX_WIDTH(MAX_W)) DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in),
        .pix_out   (pix_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Words waiting to be sent and sharpened pixels still owed by the block.
    word_t  feed_q[$];
    sharp_t sharp_q[$];
    int     errors;
    int     cycles;
    bit     quiet_send;
    bit     quiet_recv;
    int     hold_asks;
    int     hold_seen;

    // Shadow of the filter state.
    logic [7:0]  lines[STORE_ROWS * MAX_W];
    int          wr_row, wr_col, rd_row, rd_col;
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [9:0]  gain_reg;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int eff_width();
        int w;
        begin
            w = width_reg;
            if (w < MIN_SIDE) w = MIN_SIDE;
            if (w > MAX_W) w = MAX_W;
            return w;
        end
    endfunction

    function automatic int eff_height();
        begin
            return (height_reg < MIN_SIDE) ? MIN_SIDE : int'(height_reg);
        end
    endfunction

    function automatic int line_addr(int r, int c);
        begin
            return (r % STORE_ROWS) * MAX_W + (c % MAX_W);
        end
    endfunction

    // Reflect a window offset back into the image about the center pixel.
    function automatic int reflect(int center, int off, int lim);
        int k;
        begin
            k = center + off;
            if (k < 0 || k >= lim) k = center - off;
            if (k < 0) k = 0;
            return k;
        end
    endfunction

    function automatic logic [7:0] sharpen_px(int r, int c, int w, int h);
        int ctr, sum, blur, v, rr;
        begin
            ctr = lines[line_addr(r, c)];
            if (r == 0 || c == 0 || r + 1 >= h || c + 1 >= w) return ctr[7:0];
            sum = 0;
            for (int dy = -2; dy <= 2; dy++)
            begin
                rr = reflect(r, dy, h);
                for (int dx = -2; dx <= 2; dx++)
                begin
                    sum += lines[line_addr(rr, reflect(c, dx, w))];
                end
            end
            blur = (2 * sum + 25) / 50;
            v = ctr * 256 + int'(gain_reg) * (ctr - blur) + 128;
            if (v < 0) return 8'd0;
            v = v / 256;
            return (v > 255) ? 8'd255 : v[7:0];
        end
    endfunction

    // Advance the shadow state by one accepted word.
    function automatic void sharpen_step(word_t wd);
        int w, h, recv, owed;
        bit done, emit, last;
        sharp_t s;
        begin
            w = eff_width();
            h = eff_height();
            done = wr_row >= h;
            if (wd.action == ACT_PIXEL && !done)
            begin
                lines[line_addr(wr_row, wr_col)] = wd.pixel;
                wr_col++;
                if (wr_col >= w)
                begin
                    wr_col = 0;
                    wr_row++;
                end
                done = wr_row >= h;
                recv = done ? h * w : wr_row * w + wr_col;
                owed = rd_row * w + rd_col + 2 * w + 2;
                emit = done || recv > owed;
            end
            else
            begin
                emit = done;
            end
            if (emit)
            begin
                last = rd_row > h - 1 || (rd_row == h - 1 && rd_col >= w - 1);
                s.pixel = sharpen_px(rd_row, rd_col, w, h);
                s.frame_end = last;
                sharp_q.push_back(s);
                if (last)
                begin
                    wr_row = 0;
                    wr_col = 0;
                    rd_row = 0;
                    rd_col = 0;
                end
                else
                begin
                    rd_col++;
                    if (rd_col >= w)
                    begin
                        rd_col = 0;
                        rd_row++;
                    end
                end
            end
        end
    endfunction

    function automatic int pick_gap(bit quiet);
        int p;
        begin
            if (quiet) return 0;
            p = $urandom_range(99);
            if (p < 60) return 0;
            if (p < 95) return $urandom_range(3, 1);
            return $urandom_range(40, 10);
        end
    endfunction

    // Sender: one word per handshake, with random gaps.
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_in.valid <= 1'b0;
            pix_in.action <= ACT_PIXEL;
            pix_in.pixel_in <= 8'd0;
            send_gap = 0;
        end
        else if (!pix_in.valid || pix_in.ready)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                pix_in.valid <= 1'b0;
            end
            else if (feed_q.size() > 0)
            begin
                word_t wd;
                wd = feed_q.pop_front();
                pix_in.valid <= 1'b1;
                pix_in.action <= wd.action;
                pix_in.pixel_in <= wd.pixel;
                send_gap = pick_gap(quiet_send);
            end
            else
            begin
                pix_in.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when asked.
    int hold_left;
    int recv_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_out.ready <= 1'b0;
            hold_left = 0;
            recv_gap = 0;
        end
        else
        begin
            if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pix_out.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                pix_out.ready <= 1'b0;
            end
            else
            begin
                pix_out.ready <= 1'b1;
                recv_gap = pick_gap(quiet_recv);
            end
        end
    end

    // Input monitor feeds the predictor with each accepted word.
    always @(posedge clk)
    begin
        if (rst_n && pix_in.valid && pix_in.ready)
        begin
            sharpen_step(word_t'{action: pix_in.action, pixel: pix_in.pixel_in});
        end
    end

    // Output monitor compares each accepted word with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && pix_out.valid && pix_out.ready)
        begin
            if (sharp_q.size() == 0)
            begin
                $display("%0t: unexpected word pixel_out=%0d frame_end=%0d", $time,
                         pix_out.pixel_out, pix_out.frame_end);
                errors++;
            end
            else
            begin
                sharp_t s;
                s = sharp_q.pop_front();
                if (pix_out.pixel_out !== s.pixel)
                begin
                    $display("%0t: pixel_out expected %0d actual %0d", $time,
                             s.pixel, pix_out.pixel_out);
                    errors++;
                end
                if (pix_out.frame_end !== s.frame_end)
                begin
                    $display("%0t: frame_end expected %0d actual %0d", $time,
                             s.frame_end, pix_out.frame_end);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Wait until the block has drained and settled.
    task automatic wait_idle();
        begin
            while (feed_q.size() > 0 || pix_in.valid || sharp_q.size() > 0)
            begin
                @(posedge clk);
            end
            repeat (20) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            if (idx == CFG_IMAGE_WIDTH) width_reg = val[10:0];
            else if (idx == CFG_IMAGE_HEIGHT) height_reg = val;
            else if (idx == CFG_SHARPEN_GAIN) gain_reg = val[9:0];
            @(posedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    // Queue one whole frame: pixels with stray flushes, then the drain.
    // Style 0 random, 1 extremes checkerboard, 2 all 255, 3 all 0.
    task automatic queue_frame(int style, bit noise);
        int w, h, n;
        word_t wd;
        begin
            w = eff_width();
            h = eff_height();
            for (int i = 0; i < w * h; i++)
            begin
                if (noise && $urandom_range(99) < 5)
                begin
                    wd.action = ACT_FLUSH;
                    wd.pixel = 8'($urandom);
                    feed_q.push_back(wd);
                end
                wd.action = ACT_PIXEL;
                case (style)
                    1: wd.pixel = (((i % w) + (i / w)) % 2) ? 8'd255 : 8'd0;
                    2: wd.pixel = 8'd255;
                    3: wd.pixel = 8'd0;
                    default: wd.pixel = 8'($urandom);
                endcase
                feed_q.push_back(wd);
            end
            // A pixel after the frame is complete also drains one result.
            n = 2 * w + 2;
            for (int i = 0; i < n; i++)
            begin
                wd.action = (noise && $urandom_range(99) < 20) ? ACT_PIXEL : ACT_FLUSH;
                wd.pixel = 8'($urandom);
                feed_q.push_back(wd);
            end
            if (noise)
            begin
                for (int i = 0; i < $urandom_range(2); i++)
                begin
                    wd.action = ACT_FLUSH;
                    wd.pixel = 8'($urandom);
                    feed_q.push_back(wd);
                end
            end
        end
    endtask

    task automatic run_frame(int w, int h, int g, int style, bit noise);
        begin
            wait_idle();
            write_reg(CFG_IMAGE_WIDTH, 16'(w));
            write_reg(CFG_IMAGE_HEIGHT, 16'(h));
            write_reg(CFG_SHARPEN_GAIN, 16'(g));
            queue_frame(style, noise);
        end
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        hold_asks = 0;
        hold_seen = 0;
        quiet_send = 1'b0;
        quiet_recv = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data = 16'd0;
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        gain_reg = GAIN_RESET;
        wr_row = 0;
        wr_col = 0;
        rd_row = 0;
        rd_col = 0;
        foreach (lines[i]) lines[i] = 8'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames: extremes of pixel and gain, clamped sizes.
        run_frame(5, 5, 512, 1, 1'b0);
        run_frame(5, 5, 0, 1, 1'b0);
        run_frame(6, 5, 512, 2, 1'b0);
        run_frame(0, 0, 1023, 3, 1'b1);
        run_frame(7, 6, 77, 0, 1'b1);

        // Long receiver hold-off while the sender keeps offering words.
        run_frame(40, 8, $urandom_range(1023), 0, 1'b0);
        quiet_send = 1'b1;
        hold_asks++;
        wait_idle();
        quiet_send = 1'b0;

        // Random small frames.
        for (int f = 0; f < 13; f++)
        begin
            quiet_send = ($urandom_range(4) == 0);
            quiet_recv = ($urandom_range(4) == 0);
            run_frame($urandom_range(12, 5), $urandom_range(9, 5),
                      $urandom_range(1023), 0, 1'b1);
        end
        quiet_send = 1'b0;
        quiet_recv = 1'b0;
        run_frame(5, 20, 512, 0, 1'b1);

        wait_idle();
        if (errors == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
